FILE: rtl/tiger_tree_tag_base32_extract_assert.svh
// Assertion macros used by the checker file of the tag extractor
`ifndef TIGER_TREE_TAG_BASE32_EXTRACT_ASSERT_SVH
`define TIGER_TREE_TAG_BASE32_EXTRACT_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define TTB_ASSERT_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tag extractor check failed");

// Next-cycle implication, disabled during reset
`define TTB_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tag extractor check failed");

`endif

FILE: rtl/tth_b32_pkg.sv
// Types, constants and character helpers for the tag extractor
`default_nettype none

package tth_b32_pkg;

  localparam int ByteW     = 8;
  localparam int WordW     = 64;
  localparam int HashW     = 3 * WordW;
  localparam int StatusW   = 2;
  localparam int OutFieldW = StatusW + HashW;
  localparam int OutTdataW = ((OutFieldW + 7) / 8) * 8;
  localparam int DigitW    = 6;
  localparam int TagW      = 2;
  localparam int DigitBitW = 5;
  localparam int LastBitW  = 2;

  localparam logic [DigitW-1:0] DigitsTotal = 6'd39;
  localparam logic [DigitW-1:0] DigitsLast  = 6'd38;

  localparam logic [ByteW-1:0] CharT     = 8'h54;
  localparam logic [ByteW-1:0] CharH     = 8'h48;
  localparam logic [ByteW-1:0] CharColon = 8'h3a;
  localparam logic [ByteW-1:0] CharA     = 8'h41;
  localparam logic [ByteW-1:0] CharZ     = 8'h5a;
  localparam logic [ByteW-1:0] Char2     = 8'h32;
  localparam logic [ByteW-1:0] Char7     = 8'h37;
  localparam logic [ByteW-1:0] DigitBase = 8'd26;

  // matcher result: 0..3 chars matched, 4 = tag complete
  localparam logic [2:0] TagDone = 3'd4;

  localparam logic [StatusW-1:0] StNone = 2'd0;
  localparam logic [StatusW-1:0] StHash = 2'd1;
  localparam logic [StatusW-1:0] StBad  = 2'd2;

  typedef enum logic [3:0] {
    PH_SEARCH = 4'b0001,
    PH_DECODE = 4'b0010,
    PH_DONE   = 4'b0100,
    PH_FAIL   = 4'b1000
  } phase_t;

  typedef struct packed {
    phase_t            phase;
    logic [TagW-1:0]   tag_prog;
    logic [DigitW-1:0] digit_cnt;
  } scan_state_t;

  localparam scan_state_t ScanReset = '{phase: PH_SEARCH, tag_prog: '0, digit_cnt: '0};

  // prefix automaton for "TTH:"
  function automatic logic [2:0] tag_next(input logic [TagW-1:0] p, input logic [ByteW-1:0] c);
    logic [2:0] r;
    r = 3'd0;
    case (p)
      2'd0: r = (c == CharT) ? 3'd1 : 3'd0;
      2'd1: r = (c == CharT) ? 3'd2 : 3'd0;
      2'd2: r = (c == CharH) ? 3'd3 : ((c == CharT) ? 3'd2 : 3'd0);
      2'd3: r = (c == CharColon) ? TagDone : ((c == CharT) ? 3'd1 : 3'd0);
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  // {valid, value}
  function automatic logic [DigitBitW:0] b32_value(input logic [ByteW-1:0] c);
    logic [DigitBitW:0] r;
    r = '0;
    if (c >= CharA && c <= CharZ) begin
      r = {1'b1, DigitBitW'(c - CharA)};
    end else if (c >= Char2 && c <= Char7) begin
      r = {1'b1, DigitBitW'(c - Char2 + DigitBase)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/tth_b32_step.sv
// Next-state logic of the tag matcher and base32 shift-in for one character
`default_nettype none

module tth_b32_step (
  input  tth_b32_pkg::scan_state_t       cur,
  input  logic [tth_b32_pkg::HashW-1:0]   acc,
  input  logic [tth_b32_pkg::ByteW-1:0]   text_byte,
  output tth_b32_pkg::scan_state_t       nxt,
  output logic [tth_b32_pkg::HashW-1:0]   acc_next,
  output logic [tth_b32_pkg::StatusW-1:0] status
);
  import tth_b32_pkg::*;

  logic [2:0]           tag;
  logic [DigitBitW:0]   digit;
  logic                 digit_ok;
  logic [DigitBitW-1:0] digit_val;

  assign tag       = tag_next(cur.tag_prog, text_byte);
  assign digit     = b32_value(text_byte);
  assign digit_ok  = digit[DigitBitW];
  assign digit_val = digit[DigitBitW-1:0];

  always_comb begin
    nxt      = cur;
    acc_next = acc;
    case (cur.phase)
      PH_SEARCH: begin
        if (tag == TagDone) begin
          nxt.phase     = PH_DECODE;
          nxt.tag_prog  = '0;
          nxt.digit_cnt = '0;
          acc_next      = '0;
        end else begin
          nxt.tag_prog = tag[TagW-1:0];
        end
      end
      PH_DECODE: begin
        if (!digit_ok) begin
          nxt.phase = PH_FAIL;
        end else if (cur.digit_cnt < DigitsLast) begin
          acc_next      = {acc[HashW-DigitBitW-1:0], digit_val};
          nxt.digit_cnt = cur.digit_cnt + 6'd1;
        end else begin
          // last character only gives its top two bits
          acc_next      = {acc[HashW-LastBitW-1:0], digit_val[DigitBitW-1 -: LastBitW]};
          nxt.digit_cnt = DigitsTotal;
          nxt.phase     = PH_DONE;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    case (nxt.phase)
      PH_SEARCH: status = StNone;
      PH_DONE:   status = StHash;
      default:   status = StBad;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/tiger_tree_tag_base32_extract.sv
// Top level: finds "TTH:" in a byte stream and decodes the base32 hash after it
//
//   channel   dir  fields (lowest bit first)                       per transfer
//   s_axis    in   tdata: text_byte; tlast: string_end              one character
//   m_axis    out  tdata: status, hash_high, hash_mid, hash_low     one per string
//
// One character per cycle unless a tlast character is stalled; each character is
// first held in the input register, then the matcher/decoder updates the scan
// state and, on tlast, loads the result register.
// A waiting result stalls only a character carrying tlast; others keep flowing.
// rst is synchronous and clears the scan state and both valid flags.
`default_nettype none

module tiger_tree_tag_base32_extract (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [tth_b32_pkg::ByteW-1:0]       s_axis_tdata,  // text_byte
  input  logic                                s_axis_tlast,  // string_end
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // status, hash_high, hash_mid, hash_low, zero padding
  output logic [tth_b32_pkg::OutTdataW-1:0]   m_axis_tdata
);
  import tth_b32_pkg::*;

  logic              in_valid;
  logic [ByteW-1:0]  in_byte;
  logic              in_last;

  scan_state_t       scan;
  scan_state_t       scan_next;
  logic [HashW-1:0]  acc;
  logic [HashW-1:0]  acc_next;
  logic [StatusW-1:0] status_next;

  logic out_free;
  logic proc;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign proc          = in_valid && (!in_last || out_free);
  assign s_axis_tready = !in_valid || proc;

  tth_b32_step u_step (
    .cur       (scan),
    .acc       (acc),
    .text_byte (in_byte),
    .nxt       (scan_next),
    .acc_next  (acc_next),
    .status    (status_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan <= ScanReset;
    end else if (proc) begin
      scan <= in_last ? ScanReset : scan_next;
    end
  end

  // accumulator is cleared when the tag is found, so no reset needed
  always_ff @(posedge clk) begin
    if (proc) begin
      acc <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (proc && in_last) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && in_last) begin
      if (status_next == StHash) begin
        m_axis_tdata <= {{(OutTdataW-OutFieldW){1'b0}},
                         acc_next[WordW-1:0], acc_next[2*WordW-1:WordW],
                         acc_next[HashW-1:2*WordW], status_next};
      end else begin
        m_axis_tdata <= {{(OutTdataW-StatusW){1'b0}}, status_next};
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tth_b32_checker.sv
// Port-level checks on the tag extractor, bound to the top level
`default_nettype none
`include "tiger_tree_tag_base32_extract_assert.svh"

module tth_b32_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [tth_b32_pkg::OutTdataW-1:0] m_axis_tdata
);
  import tth_b32_pkg::*;

  `TTB_ASSERT_NOW(a_status_legal, clk, rst, m_axis_tvalid,
    (m_axis_tdata[StatusW-1:0] == StNone) || (m_axis_tdata[StatusW-1:0] == StHash) ||
    (m_axis_tdata[StatusW-1:0] == StBad))
  `TTB_ASSERT_NOW(a_hash_zero, clk, rst,
    m_axis_tvalid && (m_axis_tdata[StatusW-1:0] != StHash),
    m_axis_tdata[OutFieldW-1:StatusW] == '0)
  `TTB_ASSERT_NOW(a_pad_zero, clk, rst, m_axis_tvalid,
    m_axis_tdata[OutTdataW-1:OutFieldW] == '0)
  `TTB_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind tiger_tree_tag_base32_extract tth_b32_checker u_checker (.*);

`default_nettype wire
